[rtl/ssd_bm_pkg.sv]
// Shared types and constants for the SSD block-matching disparity unit.
// No dependencies; used by every module under rtl/.
package ssd_bm_pkg;

   localparam int MAX_RADIUS_DEF = 7;
   localparam int COORD_BITS_DEF = 12;

   localparam int PIXEL_BITS  = 8;
   localparam int SQ_BITS     = 2 * PIXEL_BITS;
   localparam int SUM_BITS    = 24;
   localparam int RADIUS_BITS = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 3'd3;
   localparam logic [SUM_BITS-1:0]    SUM_MAX      = {SUM_BITS{1'b1}};

   typedef struct packed {
      logic kind;         // 0 reference pixel, 1 candidate pixel
      logic last_pixel;
      logic last_window;
   } ctl_type;

   localparam logic KIND_REF  = 1'b0;
   localparam logic KIND_CAND = 1'b1;

endpackage

[rtl/ssd_bm_front.sv]
// Front end: accepts requests, tracks the window index, holds the reference
// window memory and squares the pixel difference. Depends on ssd_bm_pkg.
module ssd_bm_front #(
   parameter int MAX_RADIUS = ssd_bm_pkg::MAX_RADIUS_DEF,
   parameter int COORD_BITS = ssd_bm_pkg::COORD_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_wen,
   input  logic [ssd_bm_pkg::RADIUS_BITS-1:0]      csr_wdata,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  ssd_bm_pkg::ctl_type                     in_ctl,
   input  logic [ssd_bm_pkg::PIXEL_BITS-1:0]       in_pixel,
   input  logic [COORD_BITS-1:0]                   in_ref_x,
   input  logic [COORD_BITS-1:0]                   in_cand_x,
   input  logic                                    q_full,
   output logic                                    q_push,
   output ssd_bm_pkg::ctl_type                     q_ctl,
   output logic [ssd_bm_pkg::SQ_BITS-1:0]          q_sq,
   output logic [COORD_BITS-1:0]                   q_ref_x,
   output logic [COORD_BITS-1:0]                   q_cand_x
);

   localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
   localparam int WIN_MAX  = SIDE_MAX * SIDE_MAX;
   localparam int IDX_W    = $clog2(WIN_MAX);
   localparam int CNT_W    = $clog2(WIN_MAX + 1);

   function automatic logic [CNT_W-1:0] win_count(input logic [ssd_bm_pkg::RADIUS_BITS-1:0] radius);
      int r;
      int side;
      r = int'(radius);
      if (r < 1) r = 1;
      if (r > MAX_RADIUS) r = MAX_RADIUS;
      side = 2 * r + 1;
      return CNT_W'(side * side);
   endfunction

   logic [CNT_W-1:0]                    count_ff;
   logic [IDX_W-1:0]                    pixel_index_ff, pixel_index_in;
   logic [IDX_W-1:0]                    idx;
   logic [CNT_W-1:0]                    idx_inc;
   logic                                accept;

   logic [ssd_bm_pkg::PIXEL_BITS-1:0]   mem [WIN_MAX];
   logic [ssd_bm_pkg::PIXEL_BITS-1:0]   ref_pixel_ff;

   logic                                s1_valid_ff, s1_valid_in;
   ssd_bm_pkg::ctl_type                 s1_ctl_ff;
   logic [ssd_bm_pkg::PIXEL_BITS-1:0]   s1_pixel_ff;
   logic [COORD_BITS-1:0]               s1_ref_x_ff;
   logic [COORD_BITS-1:0]               s1_cand_x_ff;

   logic [ssd_bm_pkg::PIXEL_BITS-1:0]   diff;
   logic [ssd_bm_pkg::SQ_BITS-1:0]      diff_w;

   assign in_ready = !s1_valid_ff || !q_full;
   assign accept   = in_valid && in_ready;
   assign q_push   = s1_valid_ff && !q_full;

   always_comb begin
      idx     = (CNT_W'(pixel_index_ff) < count_ff) ? pixel_index_ff : '0;
      idx_inc = CNT_W'(idx) + CNT_W'(1);
      if (in_ctl.last_pixel || idx_inc >= count_ff) begin
         pixel_index_in = '0;
      end else begin
         pixel_index_in = idx_inc[IDX_W-1:0];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (q_push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= win_count(ssd_bm_pkg::RADIUS_RESET);
         pixel_index_ff <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         if (csr_wen) count_ff <= win_count(csr_wdata);
         if (accept) pixel_index_ff <= pixel_index_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_ctl.kind == ssd_bm_pkg::KIND_REF) mem[idx] <= in_pixel;
      if (accept) begin
         ref_pixel_ff <= mem[idx];
         s1_ctl_ff    <= in_ctl;
         s1_pixel_ff  <= in_pixel;
         s1_ref_x_ff  <= in_ref_x;
         s1_cand_x_ff <= in_cand_x;
      end
   end

   always_comb begin
      diff   = (s1_pixel_ff >= ref_pixel_ff) ? s1_pixel_ff - ref_pixel_ff
                                             : ref_pixel_ff - s1_pixel_ff;
      diff_w = {{ssd_bm_pkg::PIXEL_BITS{1'b0}}, diff};
   end

   assign q_sq     = diff_w * diff_w;
   assign q_ctl    = s1_ctl_ff;
   assign q_ref_x  = s1_ref_x_ff;
   assign q_cand_x = s1_cand_x_ff;

endmodule

[rtl/ssd_bm_queue.sv]
// Short register queue between the front end and the accumulator.
// Depends on ssd_bm_pkg for the control struct and depth.
module ssd_bm_queue #(
   parameter int COORD_BITS = ssd_bm_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  ssd_bm_pkg::ctl_type                push_ctl,
   input  logic [ssd_bm_pkg::SQ_BITS-1:0]     push_sq,
   input  logic [COORD_BITS-1:0]              push_ref_x,
   input  logic [COORD_BITS-1:0]              push_cand_x,
   output logic                               full,
   input  logic                               pop,
   output logic                               out_valid,
   output ssd_bm_pkg::ctl_type                out_ctl,
   output logic [ssd_bm_pkg::SQ_BITS-1:0]     out_sq,
   output logic [COORD_BITS-1:0]              out_ref_x,
   output logic [COORD_BITS-1:0]              out_cand_x
);

   localparam int DEPTH = ssd_bm_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ssd_bm_pkg::ctl_type              ctl_mem   [DEPTH];
   logic [ssd_bm_pkg::SQ_BITS-1:0]   sq_mem    [DEPTH];
   logic [COORD_BITS-1:0]            ref_x_mem [DEPTH];
   logic [COORD_BITS-1:0]            cand_x_mem[DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);

   always_comb begin
      wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_in;
         if (pop) rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctl_mem[wr_ptr_ff]    <= push_ctl;
         sq_mem[wr_ptr_ff]     <= push_sq;
         ref_x_mem[wr_ptr_ff]  <= push_ref_x;
         cand_x_mem[wr_ptr_ff] <= push_cand_x;
      end
   end

   assign out_ctl    = ctl_mem[rd_ptr_ff];
   assign out_sq     = sq_mem[rd_ptr_ff];
   assign out_ref_x  = ref_x_mem[rd_ptr_ff];
   assign out_cand_x = cand_x_mem[rd_ptr_ff];

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> out_valid)
      else $error("queue pop while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

[rtl/ssd_bm_back.sv]
// Back end: accumulates squared differences, tracks the running minimum
// and holds the response register. Depends on ssd_bm_pkg.
module ssd_bm_back #(
   parameter int COORD_BITS = ssd_bm_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   output logic                               q_pop,
   input  ssd_bm_pkg::ctl_type                q_ctl,
   input  logic [ssd_bm_pkg::SQ_BITS-1:0]     q_sq,
   input  logic [COORD_BITS-1:0]              q_ref_x,
   input  logic [COORD_BITS-1:0]              q_cand_x,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [ssd_bm_pkg::SUM_BITS-1:0]    out_window_cost,
   output logic [COORD_BITS-1:0]              out_window_x,
   output logic [COORD_BITS-1:0]              out_best_x,
   output logic [ssd_bm_pkg::SUM_BITS-1:0]    out_best_cost,
   output logic [COORD_BITS:0]                out_disparity,
   output logic                               out_search_done
);

   localparam int SW = ssd_bm_pkg::SUM_BITS;

   logic [SW-1:0]          running_sum_ff, min_cost_ff;
   logic [COORD_BITS-1:0]  min_pos_ff, ref_col_ff;
   logic                   have_min_ff;
   logic                   out_valid_ff;

   logic [SW-1:0]          cost_ff, best_cost_ff;
   logic [COORD_BITS-1:0]  window_x_ff, best_x_ff;
   logic [COORD_BITS:0]    disparity_ff;
   logic                   done_ff;

   logic                   ends_window;
   logic [SW:0]            sum_wide;
   logic [SW-1:0]          sum_sat;
   logic                   take_min;
   logic [SW-1:0]          new_min;
   logic [COORD_BITS-1:0]  new_pos;
   logic [COORD_BITS:0]    disp;

   assign ends_window = (q_ctl.kind == ssd_bm_pkg::KIND_CAND) && q_ctl.last_pixel;
   assign q_pop       = q_valid && (!ends_window || !out_valid_ff || out_ready);

   always_comb begin
      sum_wide = {1'b0, running_sum_ff} + (SW + 1)'(q_sq);
      sum_sat  = sum_wide[SW] ? ssd_bm_pkg::SUM_MAX : sum_wide[SW-1:0];
      take_min = !have_min_ff || (sum_sat < min_cost_ff);
      new_min  = take_min ? sum_sat : min_cost_ff;
      new_pos  = take_min ? q_cand_x : min_pos_ff;
      disp     = q_ctl.last_window ? ({1'b0, ref_col_ff} - {1'b0, new_pos}) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff <= '0;
         min_cost_ff    <= '0;
         min_pos_ff     <= '0;
         have_min_ff    <= 1'b0;
         ref_col_ff     <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         out_valid_ff <= (out_valid_ff && !out_ready) || (q_pop && ends_window);
         if (q_pop) begin
            if (q_ctl.kind == ssd_bm_pkg::KIND_REF) begin
               ref_col_ff     <= q_ref_x;
               running_sum_ff <= '0;
               have_min_ff    <= 1'b0;
            end else if (!q_ctl.last_pixel) begin
               running_sum_ff <= sum_sat;
            end else begin
               running_sum_ff <= '0;
               min_cost_ff    <= new_min;
               min_pos_ff     <= new_pos;
               have_min_ff    <= !q_ctl.last_window;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && ends_window) begin
         cost_ff      <= sum_sat;
         window_x_ff  <= q_cand_x;
         best_x_ff    <= new_pos;
         best_cost_ff <= new_min;
         disparity_ff <= disp;
         done_ff      <= q_ctl.last_window;
      end
   end

   assign out_valid       = out_valid_ff;
   assign out_window_cost = cost_ff;
   assign out_window_x    = window_x_ff;
   assign out_best_x      = best_x_ff;
   assign out_best_cost   = best_cost_ff;
   assign out_disparity   = disparity_ff;
   assign out_search_done = done_ff;

`ifndef SYNTHESIS
   a_best_le_cost: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> best_cost_ff <= cost_ff)
      else $error("best cost above window cost");
   a_disp_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !done_ff |-> disparity_ff == '0)
      else $error("disparity set before search end");
   a_search_reset: assert property (@(posedge clock) disable iff (reset)
      q_pop && ends_window && q_ctl.last_window |=> !have_min_ff)
      else $error("minimum kept past search end");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ready |=> out_valid_ff && $stable(cost_ff))
      else $error("pending response overwritten");
`endif

endmodule

[rtl/ssd_block_match_disparity_unit.sv]
// Top level of the SSD stereo block-matching disparity unit.
// Depends on ssd_bm_pkg, ssd_bm_front, ssd_bm_queue and ssd_bm_back.
//
//  channel | direction | fields
//  req     | in        | tdata: pixel, ref_x, cand_x; tuser: kind, last_window; tlast: last_pixel
//  rsp     | out       | tdata: window_cost, window_x, best_x, best_cost, disparity;
//          |           | tlast: search_done
//  csr     | in        | window_radius, written on csr_wen
//
// One request per cycle while req_tready is high; the response for the request that ends
// a window leaves after reference memory read, square, accumulate into the response register.
// Reset clears the index, the search state and the two-entry queue; the reference
// window memory holds no reset value. A stalled response stops the accumulator at the
// next request that ends a window, the queue then fills and req_tready drops.
module ssd_block_match_disparity_unit #(
   parameter int MAX_RADIUS = ssd_bm_pkg::MAX_RADIUS_DEF,
   parameter int COORD_BITS = ssd_bm_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [ssd_bm_pkg::RADIUS_BITS-1:0]  csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pixel, ref_x, cand_x, zero fill
   input  logic [((ssd_bm_pkg::PIXEL_BITS + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // kind, last_window
   input  logic [1:0]                          req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // window_cost, window_x, best_x, best_cost, disparity, zero fill
   output logic [((2 * ssd_bm_pkg::SUM_BITS + 3 * COORD_BITS + 1 + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int PB     = ssd_bm_pkg::PIXEL_BITS;
   localparam int SW     = ssd_bm_pkg::SUM_BITS;
   localparam int RSP_W  = ((2 * SW + 3 * COORD_BITS + 1 + 7) / 8) * 8;

   ssd_bm_pkg::ctl_type            in_ctl, f_ctl, q_ctl;
   logic                           q_full, q_push, q_valid, q_pop;
   logic [ssd_bm_pkg::SQ_BITS-1:0] f_sq, q_sq;
   logic [COORD_BITS-1:0]          f_ref_x, f_cand_x, q_ref_x, q_cand_x;

   logic [SW-1:0]                  window_cost, best_cost;
   logic [COORD_BITS-1:0]          window_x, best_x;
   logic [COORD_BITS:0]            disparity;

   assign in_ctl.kind        = req_tuser[0];
   assign in_ctl.last_window = req_tuser[1];
   assign in_ctl.last_pixel  = req_tlast;

   ssd_bm_front #(
      .MAX_RADIUS (MAX_RADIUS),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_ctl    (in_ctl),
      .in_pixel  (req_tdata[PB-1:0]),
      .in_ref_x  (req_tdata[PB +: COORD_BITS]),
      .in_cand_x (req_tdata[PB + COORD_BITS +: COORD_BITS]),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_ctl     (f_ctl),
      .q_sq      (f_sq),
      .q_ref_x   (f_ref_x),
      .q_cand_x  (f_cand_x)
   );

   ssd_bm_queue #(
      .COORD_BITS (COORD_BITS)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (q_push),
      .push_ctl    (f_ctl),
      .push_sq     (f_sq),
      .push_ref_x  (f_ref_x),
      .push_cand_x (f_cand_x),
      .full        (q_full),
      .pop         (q_pop),
      .out_valid   (q_valid),
      .out_ctl     (q_ctl),
      .out_sq      (q_sq),
      .out_ref_x   (q_ref_x),
      .out_cand_x  (q_cand_x)
   );

   ssd_bm_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_ctl           (q_ctl),
      .q_sq            (q_sq),
      .q_ref_x         (q_ref_x),
      .q_cand_x        (q_cand_x),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_window_cost (window_cost),
      .out_window_x    (window_x),
      .out_best_x      (best_x),
      .out_best_cost   (best_cost),
      .out_disparity   (disparity),
      .out_search_done (rsp_tlast)
   );

   assign rsp_tdata = RSP_W'({disparity, best_cost, best_x, window_x, window_cost});

endmodule

[verif/ssd_block_match_disparity_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for ssd_block_match_disparity_unit: streams reference and
// candidate windows under random sender gaps and receiver stalls, predicts every window
// result in a scoreboard class. Depends on ssd_bm_pkg and the RTL under rtl/.
module ssd_block_match_disparity_unit_tb;

   localparam int COORD       = ssd_bm_pkg::COORD_BITS_DEF;
   localparam int PIXEL_BITS  = ssd_bm_pkg::PIXEL_BITS;
   localparam int SUM_BITS    = ssd_bm_pkg::SUM_BITS;
   localparam int RADIUS_BITS = ssd_bm_pkg::RADIUS_BITS;
   localparam int MAX_RADIUS  = ssd_bm_pkg::MAX_RADIUS_DEF;
   localparam int WIN_MAX     = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int REQ_W       = ((PIXEL_BITS + 2 * COORD + 7) / 8) * 8;
   localparam int RSP_W       = ((2 * SUM_BITS + 3 * COORD + 1 + 7) / 8) * 8;
   localparam int X_LO        = SUM_BITS;
   localparam int BX_LO       = SUM_BITS + COORD;
   localparam int BC_LO       = SUM_BITS + 2 * COORD;
   localparam int D_LO        = 2 * SUM_BITS + 2 * COORD;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum int {
      WIN_RANDOM,
      WIN_COPY,
      WIN_NOISE,
      WIN_PREV,
      WIN_INVERT
   } win_mode_type;

   typedef struct {
      logic                  kind;
      logic [PIXEL_BITS-1:0] pixel;
      logic [COORD-1:0]      ref_x;
      logic [COORD-1:0]      cand_x;
      logic                  last_pixel;
      logic                  last_window;
   } pixel_req_type;

   typedef struct {
      logic [SUM_BITS-1:0] window_cost;
      logic [COORD-1:0]    window_x;
      logic [COORD-1:0]    best_x;
      logic [SUM_BITS-1:0] best_cost;
      logic [COORD:0]      disparity;
      logic                search_done;
   } match_rsp_type;

   class disparity_scoreboard_type;
      logic [PIXEL_BITS-1:0]  ref_win [WIN_MAX];
      int unsigned            pix_idx, run_sum, min_cost;
      logic [COORD-1:0]       min_pos, ref_col;
      logic                   have_min;
      logic [RADIUS_BITS-1:0] radius;
      match_rsp_type          cost_q [$];
      int unsigned            errors;

      function new();
         radius   = ssd_bm_pkg::RADIUS_RESET;
         pix_idx  = 0;
         run_sum  = 0;
         min_cost = 0;
         min_pos  = '0;
         ref_col  = '0;
         have_min = 1'b0;
         errors   = 0;
      endfunction

      function int unsigned win_count();
         int unsigned r;
         r = radius;
         if (r < 1) r = 1;
         if (r > MAX_RADIUS) r = MAX_RADIUS;
         return (2 * r + 1) * (2 * r + 1);
      endfunction

      function int pending();
         return cost_q.size();
      endfunction

      function void note_request(pixel_req_type rq);
         int unsigned   cnt, idx, diff, sq;
         match_rsp_type e;
         cnt = win_count();
         idx = (pix_idx < cnt) ? pix_idx : 0;
         if (rq.kind == ssd_bm_pkg::KIND_REF) begin
            ref_win[idx] = rq.pixel;
            ref_col      = rq.ref_x;
            run_sum      = 0;
            have_min     = 1'b0;
            pix_idx      = rq.last_pixel ? 0 : ((idx + 1 < cnt) ? idx + 1 : 0);
            return;
         end
         diff = (rq.pixel >= ref_win[idx]) ? rq.pixel - ref_win[idx]
                                            : ref_win[idx] - rq.pixel;
         sq      = diff * diff;
         run_sum = (run_sum > ssd_bm_pkg::SUM_MAX - sq) ? ssd_bm_pkg::SUM_MAX
                                                        : run_sum + sq;
         if (!rq.last_pixel) begin
            pix_idx = (idx + 1 < cnt) ? idx + 1 : 0;
            return;
         end
         if (!have_min || run_sum < min_cost) begin
            min_cost = run_sum;
            min_pos  = rq.cand_x;
            have_min = 1'b1;
         end
         e.window_cost = SUM_BITS'(run_sum);
         e.window_x    = rq.cand_x;
         e.best_x      = min_pos;
         e.best_cost   = SUM_BITS'(min_cost);
         e.disparity   = rq.last_window ? {1'b0, ref_col} - {1'b0, min_pos} : '0;
         e.search_done = rq.last_window;
         cost_q = {cost_q, e};
         run_sum = 0;
         pix_idx = 0;
         if (rq.last_window) have_min = 1'b0;
      endfunction

      function void check_field(string name, int unsigned exp_v, int unsigned got);
         if (exp_v != got) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, got);
            errors++;
         end
      endfunction

      function void check_response(logic [RSP_W-1:0] data, logic last);
         match_rsp_type e;
         if (cost_q.size() == 0) begin
            $error("response with none pending: window_x %0d", data[X_LO +: COORD]);
            errors++;
            return;
         end
         e = cost_q.pop_front();
         check_field("window_cost", e.window_cost, data[0 +: SUM_BITS]);
         check_field("window_x", e.window_x, data[X_LO +: COORD]);
         check_field("best_x", e.best_x, data[BX_LO +: COORD]);
         check_field("best_cost", e.best_cost, data[BC_LO +: SUM_BITS]);
         check_field("disparity", e.disparity, data[D_LO +: COORD + 1]);
         check_field("search_done", e.search_done, last);
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_wen    = 1'b0;
   logic [RADIUS_BITS-1:0] csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata  = '0;
   logic [1:0]             req_tuser  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   rsp_tlast;

   disparity_scoreboard_type sb;
   logic [PIXEL_BITS-1:0]    prev_win [WIN_MAX];
   int unsigned              burst_left;
   int unsigned              req_count;
   int unsigned              cycle_count;
   int                       rx_mode, rx_left, rx_tick;

   ssd_block_match_disparity_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // response stall pattern: free running, coin flip, one in five, long stalls
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= $urandom_range(0, 3);
         rx_left <= $urandom_range(40, 300);
      end else begin
         rx_left <= rx_left - 1;
      end
      rx_tick <= rx_tick + 1;
      case (rx_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= (rx_tick % 5 == 0);
         default: rsp_tready <= (rx_tick % 24 < 3);
      endcase
   end

   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tlast);
   end

   task automatic send_req(logic kind, logic [PIXEL_BITS-1:0] pixel, logic [COORD-1:0] rx,
                           logic [COORD-1:0] cx, logic lastp, logic lastw);
      pixel_req_type rq;
      int unsigned   gap;
      logic          taken;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      rq.kind        = kind;
      rq.pixel       = pixel;
      rq.ref_x       = rx;
      rq.cand_x      = cx;
      rq.last_pixel  = lastp;
      rq.last_window = lastw;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({cx, rx, pixel});
      req_tuser  <= {lastw, kind};
      req_tlast  <= lastp;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      sb.note_request(rq);
      req_count++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_radius(logic [RADIUS_BITS-1:0] r);
      wait_idle();
      csr_wen   <= 1'b1;
      csr_wdata <= r;
      @(posedge clock);
      csr_wen   <= 1'b0;
      sb.radius = r;
   endtask

   task automatic load_reference(int unsigned len, logic [COORD-1:0] rx);
      int unsigned k;
      for (k = 0; k < len; k++)
         send_req(ssd_bm_pkg::KIND_REF, 8'($urandom), rx, 12'($urandom), k == len - 1,
                  1'($urandom));
   endtask

   // random pixels, copy of reference, reference plus noise, previous window or
   // inverted reference
   task automatic send_window(int unsigned len, logic [COORD-1:0] cx, logic lastw,
                              win_mode_type mode);
      int unsigned           cnt, k;
      logic [PIXEL_BITS-1:0] p;
      int                    v;
      cnt = sb.win_count();
      for (k = 0; k < len; k++) begin
         case (mode)
            WIN_RANDOM: p = 8'($urandom);
            WIN_COPY:   p = sb.ref_win[k % cnt];
            WIN_NOISE: begin
               v = int'(sb.ref_win[k % cnt]) + $urandom_range(0, 6) - 3;
               p = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
            end
            WIN_PREV:   p = (k < WIN_MAX) ? prev_win[k] : 8'($urandom);
            default:    p = ~sb.ref_win[k % cnt];
         endcase
         if (k < WIN_MAX) prev_win[k] = p;
         send_req(ssd_bm_pkg::KIND_CAND, p, 12'($urandom), cx, k == len - 1, lastw);
      end
   endtask

   initial begin
      int unsigned            k, w, cnt, nwin, sel, len, rand_start;
      logic [RADIUS_BITS-1:0] r;
      logic [COORD-1:0]       cx;
      sb = new();
      for (k = 0; k < WIN_MAX; k++) prev_win[k] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // fill every reference entry before any candidate reads one
      set_radius(3'd7);
      load_reference(WIN_MAX, 12'd100);

      set_radius(3'd1);
      for (k = 0; k < 9; k++)
         send_req(ssd_bm_pkg::KIND_REF, (k % 2) ? 8'hFF : 8'h00, 12'hFFF, 12'h000, k == 8,
                  1'b0);
      send_window(9, 12'h800, 1'b0, WIN_INVERT);
      send_window(9, 12'h000, 1'b1, WIN_COPY);
      send_req(ssd_bm_pkg::KIND_REF, 8'hA5, 12'h000, 12'hFFF, 1'b1, 1'b1);
      send_req(ssd_bm_pkg::KIND_CAND, 8'h00, 12'hFFF, 12'hFFF, 1'b1, 1'b1);

      // index left past the new window size by a radius change
      set_radius(3'd7);
      for (k = 0; k < 30; k++)
         send_req(ssd_bm_pkg::KIND_CAND, 8'($urandom), 12'($urandom), 12'h123, 1'b0, 1'b0);
      set_radius(3'd0);
      send_window(9, 12'h456, 1'b1, WIN_RANDOM);

      // overlong window drives the sum into saturation
      for (k = 0; k < 9; k++)
         send_req(ssd_bm_pkg::KIND_REF, (k % 3 == 0) ? 8'hFF : 8'h00, 12'h0F0, 12'h000,
                  k == 8, 1'b0);
      send_window(270, 12'h0AA, 1'b1, WIN_INVERT);

      rand_start = req_count;
      while (req_count - rand_start < 900) begin
         if (sb.win_count() > 49 || $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: r = 3'($urandom_range(0, 1));
               4, 5, 6:    r = 3'd2;
               7:          r = 3'd3;
               8:          r = 3'($urandom_range(4, 6));
               default:    r = 3'd7;
            endcase
            set_radius(r);
         end
         cnt = sb.win_count();
         load_reference(cnt, 12'($urandom));
         nwin = (cnt > 49) ? 1 : $urandom_range(1, 6);
         for (w = 0; w < nwin; w++) begin
            sel = $urandom_range(0, 19);
            len = cnt;
            if (sel == 0) len = $urandom_range(1, cnt);
            else if (sel == 1) len = cnt + $urandom_range(1, cnt);
            else if (sel == 2)
               send_req(ssd_bm_pkg::KIND_REF, 8'($urandom), 12'($urandom), 12'($urandom),
                        1'($urandom), 1'($urandom));
            cx = ($urandom_range(0, 15) == 0) ? {COORD{1'($urandom)}} : 12'($urandom);
            send_window(len, cx, (w == nwin - 1) && (sel != 3),
                        win_mode_type'($urandom_range(0, 4)));
         end
         if ($urandom_range(0, 7) == 0) wait_idle();
      end

      wait_idle();
      repeat (12) @(posedge clock);
      if (sb.errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

[files.f]
rtl/ssd_bm_pkg.sv
rtl/ssd_bm_front.sv
rtl/ssd_bm_queue.sv
rtl/ssd_bm_back.sv
rtl/ssd_block_match_disparity_unit.sv
verif/ssd_block_match_disparity_unit_tb.sv
